/* hdl/rgb_box_blur_3x3_defines.svh */
// assertion macros shared by the blur block
`ifndef RGB_BOX_BLUR_3X3_DEFINES_SVH
`define RGB_BOX_BLUR_3X3_DEFINES_SVH

// property must hold at every clock edge out of reset
`define RBB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rbb assertion failed");

// condition must never be seen out of reset
`define RBB_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rbb forbidden condition seen");

`endif

/* hdl/rbb_pkg.sv */
package rbb_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned WIDTH_W     = 11;
  localparam int unsigned HEIGHT_W    = 12;
  localparam int unsigned CFG_W       = 12;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned MIN_DIM     = 3;
  localparam int unsigned RECIP_W     = 12;
  localparam int unsigned RECIP_SHIFT = 15;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [ROW_W-1:0]    ROW_MAX      = '1;
  // ceil(2^15 / 9), exact for sums below 32768
  localparam logic [RECIP_W-1:0]  RECIP_9      = 12'd3641;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  // red in the lowest bits
  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic border;
    logic last;
  } res_meta_t;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } sums_t;

endpackage

/* hdl/rbb_line_buf.sv */
module rbb_line_buf import rbb_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output pixel_t        older_o,
  output pixel_t        newer_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  pixel_t        wr_older_i,
  input  pixel_t        wr_newer_i
);

  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } line_t;

  line_t mem_q [DEPTH];
  line_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= '{older: wr_older_i, newer: wr_newer_i};
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign older_o = rd_q.older;
  assign newer_o = rd_q.newer;

endmodule

/* hdl/rbb_window.sv */
module rbb_window import rbb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      in_valid_i,
  input  logic      in_emit_i,
  input  res_meta_t in_meta_i,
  input  pixel_t    older_i,
  input  pixel_t    newer_i,
  input  pixel_t    px_i,
  output logic      valid_o,
  output sums_t     sums_o,
  output pixel_t    centre_o,
  output res_meta_t meta_o
);

  // [row][col], row 0 oldest, col 2 newest
  pixel_t    win_q [3][3];
  logic      win_valid_q;
  res_meta_t win_meta_q;

  logic      s2_valid_q;
  sums_t     s2_sums_q;
  pixel_t    s2_centre_q;
  res_meta_t s2_meta_q;

  sums_t     sums_d;

  always_ff @(posedge clk_i) begin
    if (en_i && in_valid_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 2; c++) begin
          win_q[r][c] <= win_q[r][c+1];
        end
      end
      win_q[0][2] <= older_i;
      win_q[1][2] <= newer_i;
      win_q[2][2] <= px_i;
      win_meta_q  <= in_meta_i;
    end
  end

  always_comb begin
    sums_d = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sums_d.red   = sums_d.red   + SUM_W'(win_q[r][c].red);
        sums_d.green = sums_d.green + SUM_W'(win_q[r][c].green);
        sums_d.blue  = sums_d.blue  + SUM_W'(win_q[r][c].blue);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q <= 1'b0;
      s2_valid_q  <= 1'b0;
    end else if (en_i) begin
      win_valid_q <= in_valid_i && in_emit_i;
      s2_valid_q  <= win_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && win_valid_q) begin
      s2_sums_q   <= sums_d;
      s2_centre_q <= win_q[1][1];
      s2_meta_q   <= win_meta_q;
    end
  end

  assign valid_o  = s2_valid_q;
  assign sums_o   = s2_sums_q;
  assign centre_o = s2_centre_q;
  assign meta_o   = s2_meta_q;

endmodule

/* hdl/rbb_out_stage.sv */
`include "rgb_box_blur_3x3_defines.svh"

module rbb_out_stage import rbb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  sums_t     sums_i,
  input  pixel_t    centre_i,
  input  res_meta_t meta_i,
  output logic      ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  output pixel_t    m_pixel_o,
  output logic      m_last_o
);

  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  logic              out_valid_q;
  pixel_t            out_pixel_q;
  logic              out_last_q;
  logic              skid_valid_q;
  pixel_t            skid_pixel_q;
  logic              skid_last_q;

  logic              new_valid;
  pixel_t            new_pixel;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_b;
  logic              out_free;

  // floor(sum / 9) by reciprocal multiply
  assign prod_r = PROD_W'(sums_i.red)   * PROD_W'(RECIP_9);
  assign prod_g = PROD_W'(sums_i.green) * PROD_W'(RECIP_9);
  assign prod_b = PROD_W'(sums_i.blue)  * PROD_W'(RECIP_9);

  always_comb begin
    if (meta_i.border) begin
      new_pixel = centre_i;
    end else begin
      new_pixel.red   = prod_r[RECIP_SHIFT +: PIX_W];
      new_pixel.green = prod_g[RECIP_SHIFT +: PIX_W];
      new_pixel.blue  = prod_b[RECIP_SHIFT +: PIX_W];
    end
  end

  assign ready_o   = !skid_valid_q;
  assign new_valid = valid_i && !skid_valid_q;
  assign out_free  = !out_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || new_valid;
      skid_valid_q <= 1'b0;
    end else if (new_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_pixel_q <= skid_pixel_q;
        out_last_q  <= skid_last_q;
      end else if (new_valid) begin
        out_pixel_q <= new_pixel;
        out_last_q  <= meta_i.last;
      end
    end else if (new_valid) begin
      skid_pixel_q <= new_pixel;
      skid_last_q  <= meta_i.last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_pixel_o = out_pixel_q;
  assign m_last_o  = out_last_q;

  `RBB_ASSERT(a_skid_fill_cause, clk_i, rst_ni, $rose(skid_valid_q) |-> $past(out_valid_q && !m_ready_i))
  `RBB_ASSERT(a_skid_drains, clk_i, rst_ni, (skid_valid_q && m_ready_i) |=> !skid_valid_q)

endmodule

/* hdl/rgb_box_blur_3x3.sv */
// 3x3 box blur on an RGB pixel stream in raster order. Pixels enter on the s_axis side,
// one per clock at full rate while s_axis_tready is high; each interior pixel leaves as
// floor(sum of its 3x3 neighborhood / 9) per color, and border pixels (first/last row
// or column) pass through unchanged. The result for a position is released width+1
// items after the pixel at that position, so after the last pixel of a frame send
// width+1 items with tuser high (flush) to drain it; m_axis_tlast marks the final pixel
// of the frame, and the item that releases it restarts the position counters. Frame
// size comes from the image_width (index 0) and image_height (index 1) registers, width
// clamped to 3..MAX_WIDTH and height to at least 3; write them only between frames. The
// two previous rows live in one MAX_WIDTH-entry line memory with one read and one write
// per clock, which sets the one-item-per-clock rate; a result passes the s1,
// window, sum and output registers. The line memory needs no clearing after reset.
`include "rgb_box_blur_3x3_defines.svh"

module rgb_box_blur_3x3 import rbb_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,   // red_in, green_in, blue_in
  input  logic             s_axis_tuser,   // flush
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // red_out, green_out, blue_out
  output logic             m_axis_tlast    // frame_end
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned MW_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW    = (MW_W > WIDTH_W) ? MW_W : WIDTH_W;

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;

  logic [COL_W-1:0] in_col_q,  in_col_d;
  logic [ROW_W-1:0] in_row_q,  in_row_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;

  logic             s1_valid_q;
  logic             s1_emit_q;
  res_meta_t        s1_meta_q;
  pixel_t           s1_px_q;
  logic [COL_W-1:0] s1_col_q;

  logic [EW-1:0]       eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [EW:0]         in_col_inc;
  logic [EW:0]         out_col_inc;
  logic [COL_W-1:0]    col;
  logic                in_wrap;
  logic                out_wrap;
  logic                emit;
  logic                last_row;
  logic                last_col;
  res_meta_t           meta;
  pixel_t              px;
  logic                en;
  logic                s_fire;

  pixel_t    lb_older;
  pixel_t    lb_newer;
  logic      win_valid;
  sums_t     win_sums;
  pixel_t    win_centre;
  res_meta_t win_meta;
  pixel_t    res_pixel;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (EW'(width_q) < EW'(MIN_DIM)) begin
      eff_w = EW'(MIN_DIM);
    end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_q);
    end
  end

  assign eff_h = (height_q < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : height_q;

  // input and output position
  assign in_col_inc  = (EW + 1)'(in_col_q) + (EW + 1)'(1);
  assign out_col_inc = (EW + 1)'(out_col_q) + (EW + 1)'(1);
  assign in_wrap     = in_col_inc >= {1'b0, eff_w};
  assign out_wrap    = out_col_inc >= {1'b0, eff_w};
  assign col         = (EW'(in_col_q) < eff_w) ? in_col_q : COL_W'(eff_w - EW'(1));

  assign emit     = (in_row_q >= ROW_W'(2)) || (in_row_q == ROW_W'(1) && in_col_q != '0);
  assign last_row = out_row_q >= ROW_W'(eff_h - HEIGHT_W'(1));
  assign last_col = EW'(out_col_q) >= (eff_w - EW'(1));

  assign meta.last   = last_row && last_col;
  assign meta.border = (out_row_q == '0) || last_row || (out_col_q == '0) || last_col;

  assign px = s_axis_tuser ? '0 : pixel_t'(s_axis_tdata);

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (in_wrap) begin
      in_col_d = '0;
      if (in_row_q != ROW_MAX) begin
        in_row_d = in_row_q + ROW_W'(1);
      end
    end else begin
      in_col_d = COL_W'(in_col_inc);
    end
    if (emit) begin
      if (meta.last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (out_wrap) begin
        out_col_d = '0;
        out_row_d = out_row_q + ROW_W'(1);
      end else begin
        out_col_d = COL_W'(out_col_inc);
      end
    end
  end

  assign s_axis_tready = en;
  assign s_fire        = s_axis_tvalid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        in_col_q  <= in_col_d;
        in_row_q  <= in_row_d;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
      end
      if (en) begin
        s1_valid_q <= s_fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_emit_q <= emit;
      s1_meta_q <= meta;
      s1_px_q   <= px;
      s1_col_q  <= col;
    end
  end

  rbb_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i      (clk_i),
    .rd_en_i    (s_fire),
    .rd_addr_i  (col),
    .older_o    (lb_older),
    .newer_o    (lb_newer),
    .wr_en_i    (en && s1_valid_q),
    .wr_addr_i  (s1_col_q),
    .wr_older_i (lb_newer),
    .wr_newer_i (s1_px_q)
  );

  rbb_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (s1_valid_q),
    .in_emit_i  (s1_emit_q),
    .in_meta_i  (s1_meta_q),
    .older_i    (lb_older),
    .newer_i    (lb_newer),
    .px_i       (s1_px_q),
    .valid_o    (win_valid),
    .sums_o     (win_sums),
    .centre_o   (win_centre),
    .meta_o     (win_meta)
  );

  rbb_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (win_valid),
    .sums_i    (win_sums),
    .centre_i  (win_centre),
    .meta_i    (win_meta),
    .ready_o   (en),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_pixel_o (res_pixel),
    .m_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = res_pixel;

  `RBB_ASSERT(a_frame_restart, clk_i, rst_ni,
    (s_fire && emit && meta.last) |=>
    (in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0))
  `RBB_ASSERT(a_row_saturates, clk_i, rst_ni,
    (s_fire && in_row_q == ROW_MAX && !(emit && meta.last)) |=> (in_row_q == ROW_MAX))

endmodule
